FILE: rtl/fofp_pkg.sv
package fofp_pkg;

	localparam int TAG_BITS_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [7:0] CH_SOH   = 8'h01;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MSG_TYPE = 3'd0,
		REG_PRICE    = 3'd1,
		REG_QUANTITY = 3'd2,
		REG_ORD_TYPE = 3'd3,
		REG_SIDE     = 3'd4,
		REG_ORDER_ID = 3'd5
	} reg_idx_t;

	localparam logic [CFG_DATA_BITS-1:0] RST_MSG_TYPE_TAG = 16'd35;
	localparam logic [CFG_DATA_BITS-1:0] RST_PRICE_TAG    = 16'd44;
	localparam logic [CFG_DATA_BITS-1:0] RST_QUANTITY_TAG = 16'd38;
	localparam logic [CFG_DATA_BITS-1:0] RST_ORD_TYPE_TAG = 16'd40;
	localparam logic [CFG_DATA_BITS-1:0] RST_SIDE_TAG     = 16'd54;
	localparam logic [CFG_DATA_BITS-1:0] RST_ORDER_ID_TAG = 16'd37;

	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] msg_type_tag;
		logic [CFG_DATA_BITS-1:0] price_tag;
		logic [CFG_DATA_BITS-1:0] quantity_tag;
		logic [CFG_DATA_BITS-1:0] ord_type_tag;
		logic [CFG_DATA_BITS-1:0] side_tag;
		logic [CFG_DATA_BITS-1:0] order_id_tag;
	} cfg_tags_t;

	typedef enum logic [2:0] {
		SEL_NONE     = 3'd0,
		SEL_MSG_TYPE = 3'd1,
		SEL_PRICE    = 3'd2,
		SEL_QUANTITY = 3'd3,
		SEL_ORD_TYPE = 3'd4,
		SEL_SIDE     = 3'd5,
		SEL_ORDER_ID = 3'd6
	} field_sel_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_MARKET = 2'd1,
		KIND_LIMIT  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SIDE_UNSET = 2'd0,
		SIDE_BUY   = 2'd1,
		SIDE_SELL  = 2'd2
	} side_t;

	// One completed field, as seen on its closing SOH.
	typedef struct packed {
		logic       fire;
		logic       no_equals;
		field_sel_t sel;
		logic       num_ok;
		logic       is_d;
		logic       is_1;
		logic       is_2;
	} field_end_t;

	typedef struct packed {
		logic               accepted;
		logic               order_kind;
		logic [1:0]         order_side;
		logic [30:0]        order_price;
		logic [30:0]        order_quantity;
		logic signed [31:0] order_ident;
	} order_t;

endpackage

FILE: rtl/fofp_byte_if.sv
interface fofp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

FILE: rtl/fofp_order_if.sv
interface fofp_order_if;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic               order_kind;
	logic [1:0]         order_side;
	logic [30:0]        order_price;
	logic [30:0]        order_quantity;
	logic signed [31:0] order_ident;

	modport source (output valid, output accepted, output order_kind, output order_side,
		output order_price, output order_quantity, output order_ident, input ready);
	modport sink (input valid, input accepted, input order_kind, input order_side,
		input order_price, input order_quantity, input order_ident, output ready);
endinterface

FILE: rtl/fofp_cfg_if.sv
interface fofp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/fofp_cfg_regs.sv
module fofp_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	fofp_cfg_if.sink           cfg,
	output fofp_pkg::cfg_tags_t tags
);
	import fofp_pkg::*;

	cfg_tags_t tags_q;

	assign cfg.ready = 1'b1;
	assign tags      = tags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tags_q.msg_type_tag <= RST_MSG_TYPE_TAG;
			tags_q.price_tag    <= RST_PRICE_TAG;
			tags_q.quantity_tag <= RST_QUANTITY_TAG;
			tags_q.ord_type_tag <= RST_ORD_TYPE_TAG;
			tags_q.side_tag     <= RST_SIDE_TAG;
			tags_q.order_id_tag <= RST_ORDER_ID_TAG;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MSG_TYPE: tags_q.msg_type_tag <= cfg.data;
				REG_PRICE:    tags_q.price_tag    <= cfg.data;
				REG_QUANTITY: tags_q.quantity_tag <= cfg.data;
				REG_ORD_TYPE: tags_q.ord_type_tag <= cfg.data;
				REG_SIDE:     tags_q.side_tag     <= cfg.data;
				REG_ORDER_ID: tags_q.order_id_tag <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/fofp_field_scan.sv
module fofp_field_scan #(
	parameter int TAG_BITS   = fofp_pkg::TAG_BITS_DEF,
	parameter int VALUE_BITS = fofp_pkg::VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_message,
	input  logic                   reject,
	input  fofp_pkg::cfg_tags_t    tags,
	output fofp_pkg::field_end_t   field_end,
	output logic [VALUE_BITS-1:0]  value
);
	import fofp_pkg::*;

	localparam int TW = TAG_BITS + 4;
	localparam int VW = VALUE_BITS + 4;
	localparam int CW = (TAG_BITS > CFG_DATA_BITS) ? TAG_BITS : CFG_DATA_BITS;
	localparam logic [VW-1:0]         NEG_MAX_W = VW'(1) << (VALUE_BITS - 1);
	localparam logic [VALUE_BITS-1:0] NEG_MAX   = VALUE_BITS'(1) << (VALUE_BITS - 1);

	typedef struct packed {
		logic                  seen_eq;
		logic                  has_bytes;
		logic [TAG_BITS-1:0]   tag;
		logic                  t_minus;
		logic                  t_digit;
		logic                  t_stop;
		logic                  t_big;
		logic [VALUE_BITS-1:0] mag;
		logic                  v_minus;
		logic                  v_digit;
		logic                  v_stop;
		logic                  v_big;
		logic [7:0]            first_char;
		logic [1:0]            length;
	} field_t;

	field_t        fld_q, fld_n;
	logic          active_q, active_n;
	logic          is_space, is_soh, is_eq, is_minus, is_digit, act;
	logic [3:0]    digit;
	logic [TW-1:0] tag_wide;
	logic [VW-1:0] mag_wide;
	logic          tag_good, len_one;

	assign is_space = (data_byte == CH_SPACE) || (data_byte >= CH_HT && data_byte <= CH_CR);
	assign is_soh   = (data_byte == CH_SOH);
	assign is_eq    = (data_byte == CH_EQ);
	assign is_minus = (data_byte == CH_MINUS);
	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign digit    = 4'(data_byte - CH_ZERO);
	assign act      = active_q || !is_space;

	assign tag_wide = TW'(fld_q.tag) * TW'(10) + TW'(digit);
	assign mag_wide = VW'(fld_q.mag) * VW'(10) + VW'(digit);

	always_comb begin
		fld_n    = fld_q;
		active_n = active_q;
		if (!reject) begin
			active_n = act;
			if (act) begin
				if (is_soh) begin
					fld_n = '0;
				end else begin
					if (!fld_q.seen_eq) begin
						if (is_eq) begin
							fld_n.seen_eq = 1'b1;
						end else if (!fld_q.t_stop) begin
							if (is_minus && !fld_q.has_bytes) begin
								fld_n.t_minus = 1'b1;
							end else if (is_digit) begin
								fld_n.t_digit = 1'b1;
								if (!fld_q.t_big) begin
									if (tag_wide[TW-1:TAG_BITS] != '0) begin
										fld_n.t_big = 1'b1;
									end else begin
										fld_n.tag = tag_wide[TAG_BITS-1:0];
									end
								end
							end else begin
								fld_n.t_stop = 1'b1;
							end
						end
					end else begin
						if (fld_q.length == 2'd0) begin
							fld_n.first_char = data_byte;
						end
						if (fld_q.length != 2'd2) begin
							fld_n.length = 2'(fld_q.length + 2'd1);
						end
						if (!fld_q.v_stop) begin
							if (is_minus && fld_q.length == 2'd0) begin
								fld_n.v_minus = 1'b1;
							end else if (is_digit) begin
								fld_n.v_digit = 1'b1;
								if (!fld_q.v_big) begin
									if (mag_wide > NEG_MAX_W) begin
										fld_n.v_big = 1'b1;
									end else begin
										fld_n.mag = mag_wide[VALUE_BITS-1:0];
									end
								end
							end else begin
								fld_n.v_stop = 1'b1;
							end
						end
					end
					fld_n.has_bytes = 1'b1;
				end
			end
		end
		if (end_of_message) begin
			fld_n    = '0;
			active_n = 1'b0;
		end
	end

	// Field results are taken from the state before the closing SOH.
	assign tag_good = fld_q.t_digit && !fld_q.t_big && (!fld_q.t_minus || fld_q.tag == '0);
	assign len_one  = (fld_q.length == 2'd1);

	always_comb begin
		field_end.fire      = !reject && act && is_soh && fld_q.has_bytes;
		field_end.no_equals = !fld_q.seen_eq;
		field_end.num_ok    = fld_q.v_digit && !fld_q.v_big &&
			(fld_q.v_minus ? (fld_q.mag <= NEG_MAX) : (fld_q.mag < NEG_MAX));
		field_end.is_d      = len_one && fld_q.first_char == CH_D;
		field_end.is_1      = len_one && fld_q.first_char == CH_ONE;
		field_end.is_2      = len_one && fld_q.first_char == CH_TWO;
		priority if (!tag_good)                                   field_end.sel = SEL_NONE;
		else if (CW'(fld_q.tag) == CW'(tags.msg_type_tag)) field_end.sel = SEL_MSG_TYPE;
		else if (CW'(fld_q.tag) == CW'(tags.price_tag))    field_end.sel = SEL_PRICE;
		else if (CW'(fld_q.tag) == CW'(tags.quantity_tag)) field_end.sel = SEL_QUANTITY;
		else if (CW'(fld_q.tag) == CW'(tags.ord_type_tag)) field_end.sel = SEL_ORD_TYPE;
		else if (CW'(fld_q.tag) == CW'(tags.side_tag))     field_end.sel = SEL_SIDE;
		else if (CW'(fld_q.tag) == CW'(tags.order_id_tag)) field_end.sel = SEL_ORDER_ID;
		else                                                     field_end.sel = SEL_NONE;
	end

	assign value = fld_q.v_minus ? VALUE_BITS'(-fld_q.mag) : fld_q.mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fld_q    <= '0;
			active_q <= 1'b0;
		end else if (step) begin
			fld_q    <= fld_n;
			active_q <= active_n;
		end
	end

endmodule

FILE: rtl/fofp_order_build.sv
module fofp_order_build #(
	parameter int VALUE_BITS = fofp_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  end_of_message,
	input  fofp_pkg::field_end_t  field_end,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  reject,
	output fofp_pkg::order_t      result
);
	import fofp_pkg::*;

	kind_t                        kind_q, kind_n;
	side_t                        side_q, side_n;
	logic signed [VALUE_BITS-1:0] price_q, price_n;
	logic signed [VALUE_BITS-1:0] qty_q, qty_n;
	logic signed [VALUE_BITS-1:0] ident_q, ident_n;
	logic                         reject_q, reject_n;
	logic                         ok;

	assign reject = reject_q;

	always_comb begin
		kind_n   = kind_q;
		side_n   = side_q;
		price_n  = price_q;
		qty_n    = qty_q;
		ident_n  = ident_q;
		reject_n = reject_q;
		if (field_end.fire) begin
			if (field_end.no_equals) begin
				reject_n = 1'b1;
			end else begin
				unique case (field_end.sel)
					SEL_MSG_TYPE: begin
						if (field_end.is_d) kind_n = KIND_LIMIT;
						else reject_n = 1'b1;
					end
					SEL_PRICE: begin
						if (field_end.num_ok) price_n = value;
					end
					SEL_QUANTITY: begin
						if (field_end.num_ok) qty_n = value;
					end
					SEL_ORD_TYPE: begin
						if (field_end.is_1) kind_n = KIND_MARKET;
						else if (field_end.is_2) kind_n = KIND_LIMIT;
					end
					SEL_SIDE: begin
						if (field_end.is_1) side_n = SIDE_BUY;
						else if (field_end.is_2) side_n = SIDE_SELL;
					end
					SEL_ORDER_ID: begin
						if (field_end.num_ok) ident_n = value;
					end
					default: ;
				endcase
			end
		end
	end

	// The result reflects the last byte, including a closing SOH on it.
	assign ok = !reject_n && kind_n != KIND_NONE &&
		!price_n[VALUE_BITS-1] && price_n != '0 &&
		!qty_n[VALUE_BITS-1] && qty_n != '0;

	always_comb begin
		result.accepted       = ok;
		result.order_kind     = ok && kind_n == KIND_LIMIT;
		result.order_side     = ok ? side_n : SIDE_UNSET;
		result.order_price    = ok ? 31'(price_n) : '0;
		result.order_quantity = ok ? 31'(qty_n) : '0;
		result.order_ident    = ok ? 32'(ident_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_NONE;
			side_q   <= SIDE_UNSET;
			price_q  <= '0;
			qty_q    <= '0;
			ident_q  <= '0;
			reject_q <= 1'b0;
		end else if (step) begin
			if (end_of_message) begin
				kind_q   <= KIND_NONE;
				side_q   <= SIDE_UNSET;
				price_q  <= '0;
				qty_q    <= '0;
				ident_q  <= '0;
				reject_q <= 1'b0;
			end else begin
				kind_q   <= kind_n;
				side_q   <= side_n;
				price_q  <= price_n;
				qty_q    <= qty_n;
				ident_q  <= ident_n;
				reject_q <= reject_n;
			end
		end
	end

endmodule

FILE: rtl/fix_order_field_parser_core.sv
// FIX order parser: takes one message byte per word on msg, with end_of_message on the
// last byte, and gives one order word on the order channel for every message. Leading
// whitespace is skipped, fields are split at SOH and cut at their first '='; six tag
// numbers, set through cfg (index 0 message type to 5 order id), pick the fields that
// load message type, price, quantity, order kind, side and id. The per-byte update of
// the tag and value accumulators (multiply by ten, add, range check) is combinational,
// so one byte is accepted every cycle unless a last byte waits for the result register.
// A message's result is registered from its last byte in the input register, which keeps
// taking bytes while a result waits on order.ready, until a second last byte arrives.
// The user must write the tag table only while no message is in flight; no logic checks it.
module fix_order_field_parser_core #(
	parameter int TAG_BITS   = fofp_pkg::TAG_BITS_DEF,
	parameter int VALUE_BITS = fofp_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fofp_byte_if.sink     msg,
	fofp_order_if.source  order,
	fofp_cfg_if.sink      cfg
);
	import fofp_pkg::*;

	cfg_tags_t             tags;
	field_end_t            field_end;
	logic [VALUE_BITS-1:0] value;
	logic                  reject;
	order_t                result;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eom_s1;
	logic       step;
	order_t     out_q;
	logic       out_valid_q;

	// A last byte may only move on when the result register is free or being emptied.
	assign step      = valid_s1 && (!eom_s1 || !out_valid_q || order.ready);
	assign msg.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.valid && msg.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			data_s1 <= msg.data_byte;
			eom_s1  <= msg.end_of_message;
		end
	end

	fofp_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tags   (tags)
	);

	fofp_field_scan #(
		.TAG_BITS   (TAG_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_field_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.data_byte      (data_s1),
		.end_of_message (eom_s1),
		.reject         (reject),
		.tags           (tags),
		.field_end      (field_end),
		.value          (value)
	);

	fofp_order_build #(
		.VALUE_BITS (VALUE_BITS)
	) u_order_build (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.end_of_message (eom_s1),
		.field_end      (field_end),
		.value          (value),
		.reject         (reject),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && eom_s1) begin
			out_valid_q <= 1'b1;
		end else if (order.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && eom_s1) begin
			out_q <= result;
		end
	end

	assign order.valid          = out_valid_q;
	assign order.accepted       = out_q.accepted;
	assign order.order_kind     = out_q.order_kind;
	assign order.order_side     = out_q.order_side;
	assign order.order_price    = out_q.order_price;
	assign order.order_quantity = out_q.order_quantity;
	assign order.order_ident    = out_q.order_ident;

endmodule
